FILE: rtl/sitda_pkg.sv
// Shared types, constants and helper functions for the integer-to-decimal text converter.
`timescale 1ns / 1ps

package sitda_pkg;

  localparam int unsigned MagWidth  = 32;
  localparam int unsigned BcdDigits = 10;
  localparam int unsigned PtrWidth  = $clog2(BcdDigits);
  localparam int unsigned CntWidth  = $clog2(MagWidth);

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  typedef logic [BcdDigits-1:0][3:0] bcd_t;

  typedef struct packed {
    logic                neg;
    logic [MagWidth-1:0] mag;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  function automatic bcd_t bcd_adjust(input bcd_t bcd);
    bcd_t res;
    res = bcd;
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd[i] >= 4'd5) begin
        res[i] = bcd[i] + 4'd3;
      end
    end
    return res;
  endfunction

  function automatic logic [PtrWidth-1:0] lead_digit(input bcd_t bcd);
    logic [PtrWidth-1:0] idx;
    idx = '0;
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd[i] != 4'd0) begin
        idx = PtrWidth'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/signed_int_to_decimal_ascii.sv
// Output: after the conversion the characters follow one per cycle while the output accepts them.
// Numbers: n = 1..11 characters each; the converter takes no new number until the 32-step BCD
// shift loop and all characters of the last one are done, and the queue overlaps input with it.
// Reset: asynchronous, active low; clears all valid flags and returns the converter to idle.
// Contents: top level joining input stage, two-entry queue and converter.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] text_char
  output logic        m_axis_tlast    // last_char
);

  logic             fr_valid;
  logic             fr_ready;
  sitda_pkg::item_t fr_item;
  logic             q_valid;
  logic             q_ready;
  sitda_pkg::item_t q_item;

  sitda_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_value_i   (s_axis_tdata),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  sitda_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  sitda_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == sitda_pkg::CharMinus ||
                       (m_axis_tdata >= sitda_pkg::CharZero &&
                        m_axis_tdata <= sitda_pkg::CharZero + 8'd9)))
    else $error("output character out of range");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata == sitda_pkg::CharMinus) |-> !m_axis_tlast)
    else $error("minus sign marked as last character");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready) |=> !q_ready)
    else $error("converter took a second item without converting");

endmodule

FILE: rtl/sitda_front.sv
// Input stage: accept a value, split it into sign and magnitude, hold it for the queue.
`timescale 1ns / 1ps

module sitda_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sitda_pkg::MagWidth-1:0]     in_value_i,
  output logic                               item_valid_o,
  input  logic                               item_ready_i,
  output sitda_pkg::item_t                   item_o
);

  logic             vld_q, vld_d;
  sitda_pkg::item_t item_q;
  logic             take;
  logic             neg;

  assign in_ready_o   = !vld_q || item_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign neg          = in_value_i[sitda_pkg::MagWidth-1];
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (item_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.neg <= neg;
      item_q.mag <= neg ? (~in_value_i + 1'b1) : in_value_i;
    end
  end

endmodule

FILE: rtl/sitda_queue.sv
// Two-entry queue between the input stage and the converter.
`timescale 1ns / 1ps

module sitda_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  sitda_pkg::item_t push_item_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output sitda_pkg::item_t pop_item_o
);

  logic             head_vld_q, head_vld_d;
  logic             tail_vld_q, tail_vld_d;
  sitda_pkg::item_t head_q;
  sitda_pkg::item_t tail_q;
  logic             push;
  logic             pop;

  assign push_ready_o = !tail_vld_q;
  assign pop_valid_o  = head_vld_q;
  assign pop_item_o   = head_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = head_vld_q && pop_ready_i;

  always_comb begin
    head_vld_d = head_vld_q;
    tail_vld_d = tail_vld_q;
    if (pop) begin
      head_vld_d = tail_vld_q || push;
      tail_vld_d = 1'b0;
    end else if (push) begin
      if (head_vld_q) begin
        tail_vld_d = 1'b1;
      end else begin
        head_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      tail_vld_q <= tail_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      head_q <= tail_vld_q ? tail_q : push_item_i;
    end else if (push && !head_vld_q) begin
      head_q <= push_item_i;
    end
    if (push && head_vld_q && !pop) begin
      tail_q <= push_item_i;
    end
  end

endmodule

FILE: rtl/sitda_back.sv
// Converter: shift-and-add-3 binary to BCD, then character output through a register.
`timescale 1ns / 1ps

module sitda_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  sitda_pkg::item_t item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_char_o,
  output logic             out_last_o
);

  localparam logic [sitda_pkg::CntWidth-1:0] ConvLast =
    sitda_pkg::CntWidth'(sitda_pkg::MagWidth - 1);

  sitda_pkg::state_e                 state_q, state_d;
  logic [sitda_pkg::MagWidth-1:0]    mag_q;
  sitda_pkg::bcd_t                   bcd_q;
  sitda_pkg::bcd_t                   bcd_adj;
  logic [sitda_pkg::BcdDigits*4-1:0] bcd_flat;
  sitda_pkg::bcd_t                   bcd_shift;
  logic [sitda_pkg::CntWidth-1:0]    cnt_q;
  logic [sitda_pkg::PtrWidth-1:0]    ptr_q;
  logic                              neg_q;
  logic                              out_vld_q, out_vld_d;
  logic [7:0]                        out_char_q;
  logic                              out_last_q;
  logic                              slot_free;
  logic                              load;
  logic                              emit;
  logic [7:0]                        emit_char;
  logic                              emit_last;

  assign slot_free = !out_vld_q || out_ready_i;
  assign bcd_adj   = sitda_pkg::bcd_adjust(bcd_q);
  assign bcd_flat  = bcd_adj;
  assign bcd_shift = {bcd_flat[sitda_pkg::BcdDigits*4-2:0], mag_q[sitda_pkg::MagWidth-1]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      sitda_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          state_d = sitda_pkg::ST_CONV;
        end
      end
      sitda_pkg::ST_CONV: begin
        if (cnt_q == ConvLast) begin
          state_d = neg_q ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGIT;
        end
      end
      sitda_pkg::ST_SIGN: begin
        if (slot_free) begin
          state_d = sitda_pkg::ST_DIGIT;
        end
      end
      sitda_pkg::ST_DIGIT: begin
        if (slot_free && ptr_q == '0) begin
          state_d = sitda_pkg::ST_IDLE;
        end
      end
      default: state_d = sitda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready_o = 1'b0;
    load         = 1'b0;
    emit         = 1'b0;
    emit_char    = sitda_pkg::CharMinus;
    emit_last    = 1'b0;
    case (state_q)
      sitda_pkg::ST_IDLE: begin
        item_ready_o = 1'b1;
        load         = item_valid_i;
      end
      sitda_pkg::ST_SIGN: begin
        emit = slot_free;
      end
      sitda_pkg::ST_DIGIT: begin
        emit      = slot_free;
        emit_char = sitda_pkg::CharZero + {4'd0, bcd_q[ptr_q]};
        emit_last = (ptr_q == '0);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sitda_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mag_q <= item_i.mag;
      neg_q <= item_i.neg;
      bcd_q <= '0;
      cnt_q <= '0;
    end else if (state_q == sitda_pkg::ST_CONV) begin
      bcd_q <= bcd_shift;
      mag_q <= {mag_q[sitda_pkg::MagWidth-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == ConvLast) begin
        ptr_q <= sitda_pkg::lead_digit(bcd_shift);
      end
    end else if (state_q == sitda_pkg::ST_DIGIT && slot_free) begin
      ptr_q <= ptr_q - 1'b1;
    end
    if (emit) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: verif/sitda_text_checker.sv
// Checker for the decimal text converter: predicts the characters of each number and compares.
`timescale 1ns / 1ps

module sitda_text_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] text_char
  input  logic        m_axis_tlast,   // last_char
  output int          errors_o,
  output int          pending_o
);

  localparam int unsigned DecimalBase = 10;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } text_char_t;

  text_char_t expected_chars[$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic void predict_text(input logic [31:0] value);
    logic [31:0] mag;
    logic [3:0]  digit_buf [sitda_pkg::BcdDigits];
    int          nd;
    mag = value[31] ? (32'd0 - value) : value;
    nd  = 0;
    do begin
      digit_buf[nd] = 4'(mag % DecimalBase);
      mag           = mag / DecimalBase;
      nd++;
    end while (mag != 0 && nd < sitda_pkg::BcdDigits);
    if (value[31]) begin
      expected_chars.push_back('{text_char: sitda_pkg::CharMinus, last_char: 1'b0});
    end
    for (int i = nd - 1; i >= 0; i--) begin
      expected_chars.push_back('{text_char: sitda_pkg::CharZero + 8'(digit_buf[i]),
                                 last_char: (i == 0)});
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $realtime, what);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      pending_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_text(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("character %0d with nothing expected", m_axis_tdata));
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.text_char) begin
            report_mismatch($sformatf("text_char got %0d expected %0d",
                                      m_axis_tdata, want.text_char));
          end
          if (m_axis_tlast !== want.last_char) begin
            report_mismatch($sformatf("last_char got %0b expected %0b on char %0d",
                                      m_axis_tlast, want.last_char, want.text_char));
          end
        end
      end
      pending_o = expected_chars.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the decimal text converter: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int  RandomItems = 100;
  localparam int  LongHold    = 400;
  localparam int  HoldAfter   = 30;
  localparam int  DrainCycles = 60;
  localparam time RunLimit    = 6_000_000;

  localparam logic [31:0] DirectedValues [22] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'(-10), 32'd99, 32'd100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
    32'(-999999999), 32'd1234567890, 32'(-1234567890), 32'h5555_5555,
    32'hAAAA_AAAA, 32'd5, 32'(-7), 32'h0000_FFFF, 32'hFFFF_0000
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  int fail_count;
  int pending_chars;
  int sent_count;
  bit calm;

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    sent_count    = 0;
    calm          = 1'b0;
  end

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  signed_int_to_decimal_ascii DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  sitda_text_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .errors_o  (fail_count),
    .pending_o (pending_chars)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (calm || r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    int          r;
    int          k;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      v = $urandom();
    end else if (r < 7) begin
      k = $urandom_range(1, 32);
      v = $urandom() & (32'hFFFF_FFFF >> (32 - k));
      if ($urandom_range(0, 1)) v = 32'd0 - v;
    end else if (r < 9) begin
      v = 32'd1;
      k = $urandom_range(0, 9);
      repeat (k) v = v * 32'd10;
      v = v - 32'($urandom_range(0, 2)) + 32'd1;
      if ($urandom_range(0, 1)) v = 32'd0 - v;
    end else begin
      v = DirectedValues[$urandom_range(0, 21)];
    end
    return v;
  endfunction

  // enter at a falling edge, leave at a falling edge after the transfer
  task automatic send_value(input logic [31:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
    @(negedge clk_i);
  endtask

  initial begin
    int  stall_left;
    bit  held;
    stall_left = 0;
    held       = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && sent_count >= HoldAfter) begin
        // hold off long enough for the block to fill and stall its input
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        m_axis_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int waited;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DirectedValues[i]) send_value(DirectedValues[i]);
    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= 60 && n < 80);
      send_value(random_value());
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (pending_chars != 0 && waited < 100_000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(negedge clk_i);

    if (fail_count == 0 && pending_chars == 0) begin
      $display("signed_int_to_decimal_ascii regression: pass");
    end else begin
      $display("signed_int_to_decimal_ascii regression: fail");
    end
    $finish;
  end

  initial begin
    #RunLimit;
    $display("signed_int_to_decimal_ascii regression: fail");
    $finish;
  end

endmodule
